// File: rtl/blat_pkg.sv
// Shared types, register indexes and codes for the block lifecycle audit table.
package blat_pkg;

	localparam int DEF_TABLE_ENTRIES = 1024;
	localparam int DEF_WATCH_GROUPS  = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_WATCH_GROUP_0    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WATCH_VALID_MASK = 3'd4;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_DEINIT = 2'd1;
	localparam logic [1:0] OP_REUSE  = 2'd2;

	localparam logic [1:0] EV_TIER_VIOLATION = 2'd0;
	localparam logic [1:0] EV_DOUBLE_ALLOC   = 2'd1;
	localparam logic [1:0] EV_GEN_MISMATCH   = 2'd2;

	// Destination codes of a deinit request.
	localparam logic [7:0] DEST_COMMON     = 8'd0;
	localparam logic [7:0] DEST_L2         = 8'd1;
	localparam logic [7:0] DEST_QUARANTINE = 8'd2;

	// Stored state codes.
	localparam logic [7:0] STATE_COMMON     = 8'd0;
	localparam logic [7:0] STATE_UNTRUSTED  = 8'd2;
	localparam logic [7:0] STATE_L2         = 8'd2;
	localparam logic [7:0] STATE_QUARANTINE = 8'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] process_id;
		logic [31:0] thread_id;
		logic [63:0] group_id;
		logic [63:0] block_key;
		logic [7:0]  tier_code;
		logic [63:0] generation;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] event_process;
		logic [31:0] event_thread;
		logic [63:0] event_group;
		logic [63:0] event_block;
		logic [63:0] expected_generation;
		logic [63:0] actual_generation;
		logic [7:0]  from_state;
		logic [7:0]  to_state;
	} evt_word_t;

	// Request as it moves down the cell row, with the event it has picked up.
	typedef struct packed {
		logic        done;     // a cell already served this request
		logic [1:0]  opcode;
		logic [31:0] process_id;
		logic [31:0] thread_id;
		logic [63:0] group_id;
		logic [63:0] block_key;
		logic [7:0]  tier_code;
		logic [63:0] generation;
		logic        ev;       // an event is to be reported
		logic [1:0]  ev_kind;
		logic [63:0] ev_data;  // stored generation on mismatch, else stored state
	} travel_t;

	function automatic logic [7:0] deinit_state(input logic [7:0] dest);
		logic [7:0] st;
		case (dest)
			DEST_QUARANTINE: st = STATE_QUARANTINE;
			DEST_L2:         st = STATE_L2;
			default:         st = STATE_COMMON;
		endcase
		return st;
	endfunction

endpackage

// File: rtl/blat_if.sv
// Request and event channel interfaces with valid/ready handshake.
interface blat_req_if;
	import blat_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t word;
	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
	modport mon    (input valid, input ready, input word);
endinterface

interface blat_evt_if;
	import blat_pkg::*;
	logic      valid;
	logic      ready;
	evt_word_t word;
	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
	modport mon    (input valid, input ready, input word);
endinterface

// File: rtl/blat_head.sv
// Watch registers, group filter and entry register in front of the cell row.
module blat_head #(
	parameter int WATCH_GROUPS = blat_pkg::DEF_WATCH_GROUPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [blat_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [blat_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             advance,
	input  logic                             take,
	input  blat_pkg::req_word_t              word,
	output logic                             head_vld,
	output blat_pkg::travel_t                head
);
	import blat_pkg::*;

	logic [63:0]             watch_group_q [WATCH_GROUPS];
	logic [WATCH_GROUPS-1:0] watch_mask_q;
	logic                    watched;
	logic                    op_known;
	logic                    vld_s1;
	travel_t                 pay_s1;

	for (genvar g = 0; g < WATCH_GROUPS; g++) begin : g_watch
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				watch_group_q[g] <= '0;
			end else if (cfg_write_en &&
					cfg_index == REG_WATCH_GROUP_0 + CFG_INDEX_W'(g)) begin
				watch_group_q[g] <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_mask_q <= '0;
		end else if (cfg_write_en && cfg_index == REG_WATCH_VALID_MASK) begin
			watch_mask_q <= cfg_wdata[WATCH_GROUPS-1:0];
		end
	end

	always_comb begin
		watched = 1'b0;
		for (int g = 0; g < WATCH_GROUPS; g++) begin
			if (watch_mask_q[g] && watch_group_q[g] == word.group_id) begin
				watched = 1'b1;
			end
		end
	end

	assign op_known = (word.opcode == OP_ALLOC) || (word.opcode == OP_DEINIT) ||
		(word.opcode == OP_REUSE);

	// Drop unwatched words and unused opcodes here: they enter as bubbles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= take && watched && op_known;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pay_s1.done       <= 1'b0;
			pay_s1.opcode     <= word.opcode;
			pay_s1.process_id <= word.process_id;
			pay_s1.thread_id  <= word.thread_id;
			pay_s1.group_id   <= word.group_id;
			pay_s1.block_key  <= word.block_key;
			pay_s1.tier_code  <= word.tier_code;
			pay_s1.generation <= word.generation;
			pay_s1.ev         <= 1'b0;
			pay_s1.ev_kind    <= EV_TIER_VIOLATION;
			pay_s1.ev_data    <= '0;
		end
	end

	assign head_vld = vld_s1;
	assign head     = pay_s1;

endmodule

// File: rtl/blat_cell.sv
// One table slot: holds key, state and generation, serves a passing request.
module blat_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              prev_vld,
	input  blat_pkg::travel_t prev,
	output logic              nxt_vld,
	output blat_pkg::travel_t nxt
);
	import blat_pkg::*;

	logic        valid_q;
	logic [63:0] key_q;
	logic [7:0]  state_q;
	logic [63:0] gen_q;
	logic        nxt_vld_q;
	travel_t     nxt_q;

	travel_t     upd;
	logic        live;
	logic        wr_claim;
	logic        wr_state;
	logic        wr_gen;
	logic [7:0]  state_d;

	always_comb begin
		upd      = prev;
		wr_claim = 1'b0;
		wr_state = 1'b0;
		wr_gen   = 1'b0;
		state_d  = prev.tier_code;
		live     = prev_vld && !prev.done;
		if (live && valid_q && key_q == prev.block_key) begin
			upd.done = 1'b1;
			case (prev.opcode)
				OP_ALLOC: begin
					if (state_q != STATE_COMMON) begin
						upd.ev      = 1'b1;
						upd.ev_kind = EV_DOUBLE_ALLOC;
						upd.ev_data = 64'(state_q);
					end
					wr_state = 1'b1;
					wr_gen   = 1'b1;
				end
				OP_DEINIT: begin
					if (state_q == STATE_UNTRUSTED && prev.tier_code == DEST_COMMON) begin
						upd.ev      = 1'b1;
						upd.ev_kind = EV_TIER_VIOLATION;
						upd.ev_data = 64'(state_q);
					end
					wr_state = 1'b1;
					state_d  = deinit_state(prev.tier_code);
				end
				OP_REUSE: begin
					if (gen_q >= prev.generation) begin
						upd.ev      = 1'b1;
						upd.ev_kind = EV_GEN_MISMATCH;
						upd.ev_data = gen_q;
					end
					wr_gen = 1'b1;
				end
				default: ;
			endcase
		end else if (live && !valid_q && prev.opcode == OP_ALLOC) begin
			// Valid slots form a prefix of the row, so this is the first free one.
			upd.done = 1'b1;
			wr_claim = 1'b1;
			wr_state = 1'b1;
			wr_gen   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			nxt_vld_q <= 1'b0;
		end else if (advance) begin
			if (wr_claim) begin
				valid_q <= 1'b1;
			end
			nxt_vld_q <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (wr_claim) begin
				key_q <= prev.block_key;
			end
			if (wr_state) begin
				state_q <= state_d;
			end
			if (wr_gen) begin
				gen_q <= prev.generation;
			end
			nxt_q <= upd;
		end
	end

	assign nxt_vld = nxt_vld_q;
	assign nxt     = nxt_q;

endmodule

// File: rtl/block_lifecycle_audit_table.sv
// Top level of the block lifecycle audit table: head, cell row and event register.
//
//  channel  modport  direction  word        accepted when
//  req      sink     in         req_word_t  req.valid & req.ready
//  evt      source   out        evt_word_t  evt.valid & evt.ready
//  cfg      -        in         64b data    cfg_write_en
//
// One request word is taken every cycle while the event register is free or
// being drained. The head register loads at the accepting edge, then the word
// hops one cell per cycle while the row advances, passing all TABLE_ENTRIES
// cells, and lands in the event register. Latency is set by the row length.
// Reset clears the watch registers, every slot's valid flag and all pipe
// valid flags; slot contents stay unknown until a slot is claimed.
// A held event stalls the whole row at once and drops req.ready.
module block_lifecycle_audit_table #(
	parameter int TABLE_ENTRIES = blat_pkg::DEF_TABLE_ENTRIES,
	parameter int WATCH_GROUPS  = blat_pkg::DEF_WATCH_GROUPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [blat_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [blat_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	blat_req_if.sink                         req,
	blat_evt_if.source                       evt
);
	import blat_pkg::*;

	// Global shift enable: the row moves only when the event register can take a word.
	logic      advance;
	logic      chain_vld [TABLE_ENTRIES+1];
	travel_t   chain     [TABLE_ENTRIES+1];
	travel_t   last;
	logic      is_mismatch;
	evt_word_t out_word;
	logic      out_vld_q;
	evt_word_t out_word_q;

	assign advance   = !out_vld_q || evt.ready;
	assign req.ready = advance;

	blat_head #(
		.WATCH_GROUPS(WATCH_GROUPS)
	) u_head (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.advance     (advance),
		.take        (req.valid),
		.word        (req.word),
		.head_vld    (chain_vld[0]),
		.head        (chain[0])
	);

	// Each cell holds one slot; requests hop one cell per cycle while the row moves,
	// in order, so a later request always sees the updates of every earlier one.
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		blat_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.prev_vld(chain_vld[k]),
			.prev    (chain[k]),
			.nxt_vld (chain_vld[k+1]),
			.nxt     (chain[k+1])
		);
	end

	assign last        = chain[TABLE_ENTRIES];
	assign is_mismatch = (last.ev_kind == EV_GEN_MISMATCH);

	// Shape the event word; zero the fields that the kind does not use.
	always_comb begin
		out_word.event_kind    = last.ev_kind;
		out_word.event_process = last.process_id;
		out_word.event_thread  = last.thread_id;
		out_word.event_group   = last.group_id;
		out_word.event_block   = last.block_key;
		if (is_mismatch) begin
			out_word.expected_generation = last.ev_data + 64'd1;
			out_word.actual_generation   = last.generation;
			out_word.from_state          = '0;
			out_word.to_state            = '0;
		end else begin
			out_word.expected_generation = '0;
			out_word.actual_generation   = '0;
			out_word.from_state          = last.ev_data[7:0];
			out_word.to_state            = last.tier_code;
		end
	end

	// Drop requests that raised no event; hold an event until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= chain_vld[TABLE_ENTRIES] && last.ev;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= out_word;
		end
	end

	assign evt.valid = out_vld_q;
	assign evt.word  = out_word_q;

endmodule

// File: rtl/blat_checker.sv
// Port-level checks of the audit table, bound to the top level.
module blat_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_ready,
	input logic                evt_valid,
	input logic                evt_ready,
	input blat_pkg::evt_word_t evt_word
);
	import blat_pkg::*;

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid)
		else $error("event word withdrawn while stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |-> !req_ready)
		else $error("request taken while event register is stalled");

	a_mismatch_states: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_word.event_kind == EV_GEN_MISMATCH |->
			evt_word.from_state == '0 && evt_word.to_state == '0)
		else $error("generation mismatch carries state fields");

	a_other_gens: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_word.event_kind != EV_GEN_MISMATCH |->
			evt_word.expected_generation == '0 && evt_word.actual_generation == '0)
		else $error("non-mismatch event carries generations");

	a_violation_shape: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_word.event_kind == EV_TIER_VIOLATION |->
			evt_word.from_state == STATE_UNTRUSTED && evt_word.to_state == DEST_COMMON)
		else $error("tier violation with wrong states");

endmodule

bind block_lifecycle_audit_table blat_checker u_blat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_ready(req.ready),
	.evt_valid(evt.valid),
	.evt_ready(evt.ready),
	.evt_word (evt.word)
);

// File: tb/tb_block_lifecycle_audit_table.sv
// Self-checking testbench for the block lifecycle audit table.
`timescale 1ns / 100ps

module tb_block_lifecycle_audit_table;
	import blat_pkg::*;

	localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
	localparam int WATCH_GROUPS  = DEF_WATCH_GROUPS;

	// Opcode the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Long event-side hold-off; it must outlast the trip down the row.
	localparam int HOLD_CYCLES = 2 * TABLE_ENTRIES + 500;
	// Cycles without any handshake before the run is declared hung.
	localparam int QUIET_LIMIT = 4 * (HOLD_CYCLES + TABLE_ENTRIES);

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	blat_req_if req_ch ();
	blat_evt_if evt_ch ();

	block_lifecycle_audit_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.WATCH_GROUPS (WATCH_GROUPS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.evt         (evt_ch)
	);

	// Shadow of the watch registers, kept in step with every register write.
	logic [63:0] watch_grp [4];
	logic [3:0]  watch_mask;

	// Shadow of the table: one entry per stored block key. Slots are never
	// freed, so the entry count tells when the table is full.
	logic [7:0]  blk_tier [bit [63:0]];
	logic [63:0] blk_gen  [bit [63:0]];

	// Events still owed by the block, oldest first.
	evt_word_t pending_events [$];

	// Keys reused across requests so that lifecycles actually build up.
	logic [63:0] key_pool [$];

	int mismatch_count;
	bit src_gaps;
	bit sink_stalls;
	int sink_hold;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Pick one of the groups that is active right now, or a random group if none is.
	function automatic logic [63:0] watched_group();
		int i;
		if (watch_mask == '0)
			return rand64();
		do i = $urandom_range(3); while (!watch_mask[i]);
		return watch_grp[i];
	endfunction

	// Work out the event, if any, that one accepted request word causes,
	// and advance the shadow table the way the block does.
	function automatic void audit_predict(input req_word_t w);
		evt_word_t ev;
		bit watched;
		bit known;
		bit fire;
		logic [7:0] prior;
		int i;
		watched = 1'b0;
		for (i = 0; i < WATCH_GROUPS; i++)
			if (watch_mask[i] && watch_grp[i] == w.group_id)
				watched = 1'b1;
		if (!watched)
			return;
		ev = '0;
		ev.event_process = w.process_id;
		ev.event_thread  = w.thread_id;
		ev.event_group   = w.group_id;
		ev.event_block   = w.block_key;
		fire  = 1'b0;
		known = blk_tier.exists(w.block_key);
		case (w.opcode)
			OP_ALLOC: begin
				if (known && blk_tier[w.block_key] != STATE_COMMON) begin
					ev.event_kind = EV_DOUBLE_ALLOC;
					ev.from_state = blk_tier[w.block_key];
					ev.to_state   = w.tier_code;
					fire = 1'b1;
				end
				// a new key claims a free slot; with none left it is dropped
				if (known || blk_tier.num() < TABLE_ENTRIES) begin
					blk_tier[w.block_key] = w.tier_code;
					blk_gen[w.block_key]  = w.generation;
				end
			end
			OP_DEINIT: begin
				if (known) begin
					prior = blk_tier[w.block_key];
					if (prior == STATE_UNTRUSTED && w.tier_code == DEST_COMMON) begin
						ev.event_kind = EV_TIER_VIOLATION;
						ev.from_state = prior;
						ev.to_state   = w.tier_code;
						fire = 1'b1;
					end
					case (w.tier_code)
						DEST_QUARANTINE: blk_tier[w.block_key] = STATE_QUARANTINE;
						DEST_L2:         blk_tier[w.block_key] = STATE_L2;
						default:         blk_tier[w.block_key] = STATE_COMMON;
					endcase
				end
			end
			OP_REUSE: begin
				if (known) begin
					// unsigned compare; the expected value wraps past all ones
					if (blk_gen[w.block_key] >= w.generation) begin
						ev.event_kind          = EV_GEN_MISMATCH;
						ev.expected_generation = blk_gen[w.block_key] + 64'd1;
						ev.actual_generation   = w.generation;
						fire = 1'b1;
					end
					blk_gen[w.block_key] = w.generation;
				end
			end
			default: ;
		endcase
		if (fire)
			pending_events.push_back(ev);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("ERROR %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// Compare every accepted event word with the oldest one owed.
	always @(posedge clk) begin : event_check
		evt_word_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind %0d block %h",
					evt_ch.word.event_kind, evt_ch.word.event_block));
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", 64'(evt_ch.word.event_kind),
					64'(want.event_kind));
				check_field("event_process", 64'(evt_ch.word.event_process),
					64'(want.event_process));
				check_field("event_thread", 64'(evt_ch.word.event_thread),
					64'(want.event_thread));
				check_field("event_group", evt_ch.word.event_group, want.event_group);
				check_field("event_block", evt_ch.word.event_block, want.event_block);
				check_field("expected_generation", evt_ch.word.expected_generation,
					want.expected_generation);
				check_field("actual_generation", evt_ch.word.actual_generation,
					want.actual_generation);
				check_field("from_state", 64'(evt_ch.word.from_state),
					64'(want.from_state));
				check_field("to_state", 64'(evt_ch.word.to_state), 64'(want.to_state));
			end
		end
	end

	// Event side: stall at random, or hold off for a counted stretch on request.
	initial begin : sink_ready
		evt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				evt_ch.ready <= 1'b0;
				sink_hold--;
			end else begin
				evt_ch.ready <= !(sink_stalls && $urandom_range(99) < 33);
			end
		end
	end

	// End the run when no word moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Offer one request word, called at a falling edge. Valid stays high on
	// return; the caller either offers the next word or drops valid in the
	// same step, so valid never takes two assignments in one step.
	task automatic send_req(input req_word_t w);
		while (src_gaps && $urandom_range(99) < 33) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.word  <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		audit_predict(w);
		@(negedge clk);
	endtask

	// Drop valid, drain every owed event, then let the row empty out: words
	// that cause no event may still be travelling down it.
	task automatic settle_block();
		req_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (TABLE_ENTRIES + 8) @(posedge clk);
		@(negedge clk);
	endtask

	// Write all five watch registers; only ever called while the block is idle.
	task automatic program_watch(input logic [63:0] grp [4], input logic [3:0] mask);
		int i;
		for (i = 0; i < 4; i++) begin
			cfg_write_en <= 1'b1;
			cfg_index    <= REG_WATCH_GROUP_0 + CFG_INDEX_W'(i);
			cfg_wdata    <= grp[i];
			@(negedge clk);
			watch_grp[i] = grp[i];
		end
		cfg_index <= REG_WATCH_VALID_MASK;
		cfg_wdata <= 64'(mask);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		watch_mask = mask;
	endtask

	function automatic req_word_t make_req(input logic [1:0] op, input logic [63:0] key,
			input logic [7:0] tier, input logic [63:0] gen, input logic [63:0] grp);
		req_word_t w;
		w.opcode     = op;
		w.process_id = $urandom;
		w.thread_id  = $urandom;
		w.group_id   = grp;
		w.block_key  = key;
		w.tier_code  = tier;
		w.generation = gen;
		return w;
	endfunction

	// Mostly watched groups and pooled keys so lifecycles run deep; some noise.
	function automatic req_word_t random_request();
		req_word_t w;
		int r;
		w.process_id = $urandom;
		w.thread_id  = $urandom;
		r = $urandom_range(99);
		if (r < 70)
			w.group_id = watched_group();
		else if (r < 85)
			w.group_id = watch_grp[$urandom_range(3)];
		else
			w.group_id = rand64();
		r = $urandom_range(99);
		if (r < 35)
			w.opcode = OP_ALLOC;
		else if (r < 65)
			w.opcode = OP_DEINIT;
		else if (r < 95)
			w.opcode = OP_REUSE;
		else
			w.opcode = OP_UNUSED;
		if ($urandom_range(9) == 0)
			w.block_key = rand64();
		else
			w.block_key = key_pool[$urandom_range(key_pool.size() - 1)];
		r = $urandom_range(99);
		if (r < 25)
			w.tier_code = DEST_COMMON;
		else if (r < 45)
			w.tier_code = DEST_L2;
		else if (r < 65)
			w.tier_code = DEST_QUARANTINE;
		else if (r < 75)
			w.tier_code = STATE_QUARANTINE;
		else
			w.tier_code = 8'($urandom);
		r = $urandom_range(99);
		if (w.opcode == OP_REUSE && blk_gen.exists(w.block_key)) begin
			// bias around the stored generation: growing, equal, shrinking, wrapping
			if (r < 45)
				w.generation = blk_gen[w.block_key] + 64'($urandom_range(3, 1));
			else if (r < 70)
				w.generation = blk_gen[w.block_key] - 64'($urandom_range(2));
			else
				w.generation = rand64();
		end else if (r < 50) begin
			w.generation = 64'($urandom_range(1000));
		end else if (r < 65) begin
			w.generation = '1 - 64'($urandom_range(3));
		end else begin
			w.generation = rand64();
		end
		return w;
	endfunction

	// Nothing is watched out of reset, and a zero mask keeps it that way.
	task automatic test_ignored_requests();
		logic [63:0] grp [4];
		int i;
		send_req(make_req(OP_ALLOC, key_pool[0], STATE_L2, 64'd1, '0));
		send_req(make_req(OP_REUSE, key_pool[0], 8'd0, '0, rand64()));
		settle_block();
		for (i = 0; i < 4; i++)
			grp[i] = rand64();
		program_watch(grp, 4'b0000);
		send_req(make_req(OP_ALLOC, key_pool[0], STATE_L2, 64'd1, grp[0]));
		send_req(make_req(OP_DEINIT, key_pool[0], DEST_COMMON, '0, grp[3]));
		send_req(make_req(OP_UNUSED, key_pool[0], 8'd1, '1, grp[1]));
		settle_block();
	endtask

	// Walk one block through every transition, then the generation edges.
	task automatic test_lifecycle_directed();
		logic [63:0] grp [4];
		logic [63:0] k1;
		req_word_t w;
		grp[0] = '0;
		grp[1] = '1;
		grp[2] = rand64();
		grp[3] = rand64();
		// leave group 2 inactive so its words are ignored
		program_watch(grp, 4'b1011);
		k1 = key_pool[0];
		w = make_req(OP_ALLOC, k1, STATE_L2, 64'd5, grp[0]);
		w.process_id = '0;
		w.thread_id  = '0;
		send_req(w);
		// double allocation over a nonzero state; all-ones ids
		w = make_req(OP_ALLOC, k1, 8'd1, 64'd7, grp[1]);
		w.process_id = '1;
		w.thread_id  = '1;
		send_req(w);
		send_req(make_req(OP_DEINIT, k1, DEST_QUARANTINE, rand64(), grp[3]));
		send_req(make_req(OP_DEINIT, k1, DEST_COMMON, rand64(), grp[0]));
		// realloc over common state is quiet
		send_req(make_req(OP_ALLOC, k1, STATE_COMMON, 64'd9, grp[1]));
		send_req(make_req(OP_DEINIT, k1, DEST_L2, rand64(), grp[0]));
		// untrusted to common is a tier violation
		send_req(make_req(OP_DEINIT, k1, DEST_COMMON, rand64(), grp[3]));
		send_req(make_req(OP_DEINIT, k1, 8'hFF, rand64(), grp[0]));
		// generation edges on the all-ones key, then allocations on the all-zero key
		send_req(make_req(OP_ALLOC, '1, 8'hFF, '1, grp[1]));
		send_req(make_req(OP_REUSE, '1, 8'hFF, '1, grp[1]));
		send_req(make_req(OP_REUSE, '1, 8'd0, '0, grp[0]));
		send_req(make_req(OP_REUSE, '1, 8'd0, 64'd1, grp[3]));
		send_req(make_req(OP_REUSE, '1, 8'd0, 64'd1, grp[0]));
		send_req(make_req(OP_ALLOC, '1, 8'h80, 64'd3, grp[1]));
		send_req(make_req(OP_ALLOC, '0, STATE_QUARANTINE, '0, grp[0]));
		send_req(make_req(OP_ALLOC, '0, 8'd0, 64'd4, grp[0]));
		// unknown blocks stay quiet
		send_req(make_req(OP_REUSE, rand64(), 8'd0, '0, grp[0]));
		send_req(make_req(OP_DEINIT, rand64(), DEST_COMMON, '0, grp[1]));
		// ignored: unused opcode, inactive group, unlisted group
		send_req(make_req(OP_UNUSED, k1, STATE_L2, '0, grp[0]));
		send_req(make_req(OP_ALLOC, k1, 8'd7, '0, grp[2]));
		send_req(make_req(OP_ALLOC, k1, 8'd7, '0, rand64()));
		send_req(make_req(OP_REUSE, k1, 8'd0, 64'd10, grp[3]));
		settle_block();
	endtask

	task automatic test_random_traffic(input logic [3:0] mask, input bit edge_groups,
			input bit gaps, input int count);
		logic [63:0] grp [4];
		int i;
		for (i = 0; i < 4; i++)
			grp[i] = rand64();
		if (edge_groups) begin
			grp[0] = '0;
			grp[1] = '1;
		end
		program_watch(grp, mask);
		src_gaps    = gaps;
		sink_stalls = gaps;
		repeat (count) send_req(random_request());
		settle_block();
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// Hold the event side shut until an event sits at the output, then keep
	// offering words so the stalled row pushes back on the request side.
	task automatic test_event_backpressure();
		logic [63:0] k;
		k = key_pool[1];
		send_req(make_req(OP_ALLOC, k, STATE_QUARANTINE, rand64(), watched_group()));
		sink_hold = HOLD_CYCLES;
		repeat (20)
			send_req(make_req(OP_ALLOC, k, 8'($urandom_range(255, 1)), rand64(),
				watched_group()));
		req_ch.valid <= 1'b0;
		while (!evt_ch.valid)
			@(posedge clk);
		@(negedge clk);
		repeat (30) send_req(random_request());
		settle_block();
	endtask

	initial begin : run
		arst_n         = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.word    = '0;
		mismatch_count = 0;
		src_gaps       = 1'b1;
		sink_stalls    = 1'b1;
		sink_hold      = 0;
		watch_grp      = '{default: '0};
		watch_mask     = '0;
		repeat (30) key_pool.push_back(rand64());
		key_pool.push_back('0);
		key_pool.push_back('1);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_ignored_requests();
		test_lifecycle_directed();
		test_random_traffic(4'b0001, 1'b0, 1'b1, 100);
		test_random_traffic(4'b1111, 1'b1, 1'b1, 100);
		// one long stretch with no idling on either side
		test_random_traffic(4'b0110, 1'b0, 1'b0, 100);
		test_random_traffic(4'b1100, 1'b1, 1'b1, 90);
		test_event_backpressure();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/blat_pkg.sv
rtl/blat_if.sv
rtl/blat_head.sv
rtl/blat_cell.sv
rtl/block_lifecycle_audit_table.sv
rtl/blat_checker.sv
tb/tb_block_lifecycle_audit_table.sv
